@@ design/pscu_pkg.sv @@
// ----------------------------------------------------------------------------
// pscu_pkg
// Shared types, widths and constants of the PID speed controller.
// ----------------------------------------------------------------------------
package pscu_pkg;

  localparam int unsigned FRAC_BITS_DEF = 8;

  localparam int unsigned SPEED_W = 16;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DUTY_W  = 16;
  localparam int unsigned ERR_W   = SPEED_W + 1;
  localparam int unsigned DIFF_W  = ERR_W + 1;
  localparam int unsigned PROD_W  = DIFF_W + GAIN_W;
  localparam int unsigned CFG_IDX_W = 3;

  localparam logic [DUTY_W-1:0] DEFAULT_OFFSET = 16'd1400;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PROP_GAIN    = 3'd0,
    CFG_INTEG_GAIN   = 3'd1,
    CFG_DERIV_GAIN   = 3'd2,
    CFG_DUTY_FLOOR   = 3'd3,
    CFG_DUTY_CEILING = 3'd4,
    CFG_DUTY_OFFSET  = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic signed [SPEED_W-1:0] target_speed;
    logic signed [SPEED_W-1:0] measured_speed;
    logic                      clear_integral;
    logic                      manual_request;
  } in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_out;
    logic              manual_flag;
  } out_t;

  typedef struct packed {
    logic signed [GAIN_W-1:0] prop_gain;
    logic signed [GAIN_W-1:0] integ_gain;
    logic signed [GAIN_W-1:0] deriv_gain;
    logic        [DUTY_W-1:0] duty_floor;
    logic        [DUTY_W-1:0] duty_ceiling;
    logic        [DUTY_W-1:0] duty_offset;
  } cfg_t;

  typedef struct packed {
    logic signed [PROD_W-1:0] p_term;
    logic signed [PROD_W-1:0] i_term;
    logic signed [PROD_W-1:0] d_term;
    logic                     clear_integral;
    logic                     manual_request;
  } prod_t;

  // accumulator width: largest of a product and a scaled duty limit, plus
  // headroom for the four-term sum
  function automatic int unsigned acc_width(input int unsigned frac);
    int unsigned scaled_w;
    int unsigned base_w;
    scaled_w = DUTY_W + 1 + 2 * frac;
    base_w   = (PROD_W > scaled_w) ? PROD_W : scaled_w;
    return base_w + 3;
  endfunction

endpackage

@@ design/pscu_cfg_regs.sv @@
// ----------------------------------------------------------------------------
// pscu_cfg_regs
// Configuration register file: gains, duty limits and duty offset.
// ----------------------------------------------------------------------------
module pscu_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [pscu_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [pscu_pkg::DUTY_W-1:0]         cfg_data_i,
  output pscu_pkg::cfg_t                      cfg_o
);
  import pscu_pkg::*;

  localparam cfg_t CfgReset = '{
    prop_gain:    '0,
    integ_gain:   '0,
    deriv_gain:   '0,
    duty_floor:   '0,
    duty_ceiling: '0,
    duty_offset:  DEFAULT_OFFSET
  };

  cfg_t cfg_d, cfg_q;

  assign cfg_ready_o = 1'b1;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_PROP_GAIN:    cfg_d.prop_gain    = $signed(cfg_data_i);
        CFG_INTEG_GAIN:   cfg_d.integ_gain   = $signed(cfg_data_i);
        CFG_DERIV_GAIN:   cfg_d.deriv_gain   = $signed(cfg_data_i);
        CFG_DUTY_FLOOR:   cfg_d.duty_floor   = cfg_data_i;
        CFG_DUTY_CEILING: cfg_d.duty_ceiling = cfg_data_i;
        CFG_DUTY_OFFSET:  cfg_d.duty_offset  = cfg_data_i;
        default:          cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgReset;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

@@ design/pscu_err_stage.sv @@
// ----------------------------------------------------------------------------
// pscu_err_stage
// Error and difference terms, and the three gain products.
// ----------------------------------------------------------------------------
module pscu_err_stage (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  output logic            ready_o,
  input  pscu_pkg::in_t   data_i,
  input  pscu_pkg::cfg_t  cfg_i,
  output logic            valid_o,
  input  logic            ready_i,
  output pscu_pkg::prod_t data_o
);
  import pscu_pkg::*;

  logic                          valid_q;
  logic                          load;
  logic signed [ERR_W-1:0]       err;
  logic signed [DIFF_W-1:0]      diff;
  logic signed [ERR_W-1:0]       last_err_q;
  logic signed [ERR_W+GAIN_W-1:0] p_prod;
  logic signed [ERR_W+GAIN_W-1:0] i_prod;
  logic signed [PROD_W-1:0]      d_prod;
  prod_t                         data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign err    = ERR_W'(data_i.target_speed) - ERR_W'(data_i.measured_speed);
  assign diff   = DIFF_W'(last_err_q) - DIFF_W'(err);
  assign p_prod = err * cfg_i.prop_gain;
  assign i_prod = err * cfg_i.integ_gain;
  assign d_prod = diff * cfg_i.deriv_gain;

  always_comb begin
    data_d.p_term         = PROD_W'(p_prod);
    data_d.i_term         = PROD_W'(i_prod);
    data_d.d_term         = d_prod;
    data_d.clear_integral = data_i.clear_integral;
    data_d.manual_request = data_i.manual_request;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= 1'b0;
      last_err_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        last_err_q <= err;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/pscu_integ_stage.sv @@
// ----------------------------------------------------------------------------
// pscu_integ_stage
// Clamped integral update and the raw controller sum.
// ----------------------------------------------------------------------------
module pscu_integ_stage #(
  parameter  int unsigned FracBits = pscu_pkg::FRAC_BITS_DEF,
  localparam int unsigned AccW     = pscu_pkg::acc_width(FracBits)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  pscu_pkg::prod_t        data_i,
  input  pscu_pkg::cfg_t         cfg_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output logic signed [AccW-1:0] sum_o,
  output logic                   manual_o
);
  import pscu_pkg::*;

  localparam int unsigned Shift = 2 * FracBits;

  logic                   valid_q;
  logic                   load;
  logic signed [AccW-1:0] integ_q, integ_d;
  logic signed [AccW-1:0] lim;
  logic signed [AccW-1:0] offset_sc;
  logic signed [AccW-1:0] acc;
  logic signed [AccW-1:0] clamped;
  logic signed [AccW-1:0] sum_d, sum_q;
  logic                   manual_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  assign lim       = $signed(AccW'(cfg_i.duty_ceiling) << Shift);
  assign offset_sc = $signed(AccW'(cfg_i.duty_offset) << Shift);
  assign acc       = integ_q + AccW'(data_i.i_term);

  // upper bound wins first, so a zero ceiling pins the integral to zero
  always_comb begin
    if (acc >= lim) begin
      clamped = lim;
    end else if (acc <= -lim) begin
      clamped = -lim;
    end else begin
      clamped = acc;
    end
  end

  assign sum_d   = AccW'(data_i.p_term) + clamped + AccW'(data_i.d_term) + offset_sc;
  assign integ_d = data_i.clear_integral ? '0 : clamped;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      integ_q <= '0;
    end else begin
      if (ready_o) begin
        valid_q <= valid_i;
      end
      if (load) begin
        integ_q <= integ_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      sum_q    <= sum_d;
      manual_q <= data_i.manual_request;
    end
  end

  assign valid_o  = valid_q;
  assign sum_o    = sum_q;
  assign manual_o = manual_q;

endmodule

@@ design/pscu_duty_stage.sv @@
// ----------------------------------------------------------------------------
// pscu_duty_stage
// Truncation toward zero, duty limit clamp and the result register.
// ----------------------------------------------------------------------------
module pscu_duty_stage #(
  parameter  int unsigned FracBits = pscu_pkg::FRAC_BITS_DEF,
  localparam int unsigned AccW     = pscu_pkg::acc_width(FracBits)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  output logic                   ready_o,
  input  logic signed [AccW-1:0] sum_i,
  input  logic                   manual_i,
  input  pscu_pkg::cfg_t         cfg_i,
  output logic                   valid_o,
  input  logic                   ready_i,
  output pscu_pkg::out_t         data_o
);
  import pscu_pkg::*;

  localparam int unsigned Shift = 2 * FracBits;

  logic                   valid_q;
  logic                   load;
  logic        [AccW-1:0] mag;
  logic        [AccW-1:0] mag_sh;
  logic signed [AccW-1:0] trunc;
  logic signed [AccW-1:0] ceil_ext;
  logic signed [AccW-1:0] floor_ext;
  out_t                   data_d, data_q;

  assign ready_o = !valid_q || ready_i;
  assign load    = valid_i && ready_o;

  // truncate the magnitude, then restore the sign
  assign mag       = sum_i[AccW-1] ? AccW'(-sum_i) : AccW'(sum_i);
  assign mag_sh    = mag >> Shift;
  assign trunc     = sum_i[AccW-1] ? -$signed(mag_sh) : $signed(mag_sh);
  assign ceil_ext  = $signed(AccW'(cfg_i.duty_ceiling));
  assign floor_ext = $signed(AccW'(cfg_i.duty_floor));

  always_comb begin
    if (trunc > ceil_ext) begin
      data_d.duty_out = cfg_i.duty_ceiling;
    end else if (trunc < floor_ext) begin
      data_d.duty_out = cfg_i.duty_floor;
    end else begin
      data_d.duty_out = trunc[DUTY_W-1:0];
    end
    data_d.manual_flag = manual_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      data_q <= data_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = data_q;

endmodule

@@ design/pid_speed_controller_unit.sv @@
// A beat passes the input register and the error, integral and duty stages.
// Throughput: one beat per cycle unless the output stalls; each stage register
// has its own valid and fills whenever the next stage can take its beat, so
// bubbles collapse. The integral and last-error recurrences close within one
// stage each. Reset clears all valids, the integral and last error, and loads
// the config registers with their defaults (duty offset 1400, everything else 0).
// ----------------------------------------------------------------------------
// pid_speed_controller_unit
// PID speed controller with clamped integral and clamped integer duty output.
// ----------------------------------------------------------------------------
module pid_speed_controller_unit #(
  parameter int unsigned FracBits = pscu_pkg::FRAC_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  pscu_pkg::in_t                  in_data_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output pscu_pkg::out_t                 out_data_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [pscu_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [pscu_pkg::DUTY_W-1:0]    cfg_data_i
);
  import pscu_pkg::*;

  localparam int unsigned AccW = acc_width(FracBits);

  cfg_t                   cfg;
  logic                   in_valid_q;
  in_t                    in_q;
  logic                   err_ready;
  logic                   err_valid;
  prod_t                  prod;
  logic                   integ_ready;
  logic                   integ_valid;
  logic signed [AccW-1:0] sum;
  logic                   manual;
  logic                   duty_ready;

  pscu_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // input register
  assign in_ready_o = !in_valid_q || err_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
  end

  pscu_err_stage u_err (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .ready_o (err_ready),
    .data_i  (in_q),
    .cfg_i   (cfg),
    .valid_o (err_valid),
    .ready_i (integ_ready),
    .data_o  (prod)
  );

  pscu_integ_stage #(
    .FracBits (FracBits)
  ) u_integ (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (err_valid),
    .ready_o  (integ_ready),
    .data_i   (prod),
    .cfg_i    (cfg),
    .valid_o  (integ_valid),
    .ready_i  (duty_ready),
    .sum_o    (sum),
    .manual_o (manual)
  );

  pscu_duty_stage #(
    .FracBits (FracBits)
  ) u_duty (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (integ_valid),
    .ready_o  (duty_ready),
    .sum_i    (sum),
    .manual_i (manual),
    .cfg_i    (cfg),
    .valid_o  (out_valid_o),
    .ready_i  (out_ready_i),
    .data_o   (out_data_o)
  );

  // a result is either within the ceiling or pinned at the floor
  a_duty_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.duty_out <= cfg.duty_ceiling) ||
                    (out_data_o.duty_out == cfg.duty_floor))
    else $error("duty outside limits");

  // with the result register empty every stage can move, so input is open
  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input stalled with empty result register");

  // a beat in the last pipeline stage reaches the result register next cycle
  // unless the result register is holding a stalled beat
  a_pipe_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    integ_valid && (!out_valid_o || out_ready_i) |=> out_valid_o)
    else $error("pipeline beat lost before result register");

endmodule
